// ===== src/cssc_pkg.sv =====
`timescale 1ns / 1ps
// Package: shared constants for the cross stencil star counter.
package cssc_pkg;

  // Frame geometry limits
  localparam int MAX_WIDTH  = 1024;
  localparam int MAX_HEIGHT = 1024;
  localparam int COL_BITS   = $clog2(MAX_WIDTH);
  localparam int ROW_BITS   = $clog2(MAX_HEIGHT);

  // Field widths
  localparam int DIM_BITS   = 11;
  localparam int PIXEL_BITS = 8;
  localparam int COUNT_BITS = 20;
  localparam int SUM_BITS   = PIXEL_BITS + 3;

  // Star test: sum / STAR_DIV > STAR_LIMIT  <=>  sum >= STAR_DIV * (STAR_LIMIT + 1)
  localparam int STAR_DIV     = 5;
  localparam int STAR_LIMIT   = 6;
  localparam int STAR_SUM_MIN = STAR_DIV * (STAR_LIMIT + 1);

  localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

  // Configuration register indexes
  localparam logic CFG_IDX_WIDTH  = 1'b0;
  localparam logic CFG_IDX_HEIGHT = 1'b1;

endpackage

// ===== src/cross_stencil_star_counter_unit.sv =====
`timescale 1ns / 1ps
// Top level: five-point cross stencil star counter over a raster pixel stream.
// Throughput: one pixel per clock; line store reads and writes take one port each per cycle.
// A frame's count passes through stage 1 into the output register after its last pixel.
// The input stalls only while a finished count waits behind a stalled output register.
// Reset: synchronous active-low; width and height return to 1024, counters and flags clear.
// Line stores have no reset; entries are filled by the first two rows of each frame.
module cross_stencil_star_counter_unit (
  input  logic                               clk,
  input  logic                               rst_n,
  // configuration
  input  logic                               cfg_we,
  input  logic                               cfg_index,
  input  logic [cssc_pkg::DIM_BITS-1:0]      cfg_data,
  // pixel input
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic [cssc_pkg::PIXEL_BITS-1:0]    in_pixel,
  // count output
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic [cssc_pkg::COUNT_BITS-1:0]    out_star_count
);
  import cssc_pkg::*;

  // Configuration and position state
  logic [DIM_BITS-1:0]   width_r, height_r;
  logic [COL_BITS-1:0]   col_r, col_nxt;
  logic [ROW_BITS-1:0]   row_r, row_nxt;
  logic [DIM_BITS-1:0]   width_dec, height_dec;
  logic [COL_BITS-1:0]   width_m1;
  logic [ROW_BITS-1:0]   height_m1;
  logic                  col_last, row_last;

  // Line stores and their registered read data
  logic [PIXEL_BITS-1:0] up_mem  [MAX_WIDTH];
  logic [PIXEL_BITS-1:0] mid_mem [MAX_WIDTH];
  logic [PIXEL_BITS-1:0] up_rd_r, mid_rd_r;

  // Stage 1 (column c aligned with the line store reads)
  logic                  s1_valid_r, s1_valid_nxt;
  logic [PIXEL_BITS-1:0] s1_pixel_r;
  logic [COL_BITS-1:0]   s1_col_r;
  logic                  s1_row_ge2_r;
  logic                  s1_last_r;

  // Column window: previous one and two columns
  logic [PIXEL_BITS-1:0] up1_r, mid1_r, mid2_r, pix1_r;

  // Counting and output
  logic [COUNT_BITS-1:0] count_r, count_nxt;
  logic [COUNT_BITS-1:0] frame_total;
  logic [SUM_BITS-1:0]   cross_sum;
  logic                  is_center, is_star;
  logic                  out_valid_r, out_valid_nxt;
  logic [COUNT_BITS-1:0] out_count_r;

  logic                  in_acc, s1_hold, s1_adv, out_load;

  // Effective dimensions minus one (zero reads as one, oversize saturates)
  assign width_dec  = width_r - DIM_BITS'(1);
  assign height_dec = height_r - DIM_BITS'(1);

  always_comb begin
    if (width_r == '0) begin
      width_m1 = '0;
    end else if (width_r > DIM_BITS'(MAX_WIDTH)) begin
      width_m1 = COL_BITS'(MAX_WIDTH - 1);
    end else begin
      width_m1 = width_dec[COL_BITS-1:0];
    end
    if (height_r == '0) begin
      height_m1 = '0;
    end else if (height_r > DIM_BITS'(MAX_HEIGHT)) begin
      height_m1 = ROW_BITS'(MAX_HEIGHT - 1);
    end else begin
      height_m1 = height_dec[ROW_BITS-1:0];
    end
  end

  // Handshake: stage 1 holds only when a frame count cannot enter the output register
  assign s1_hold  = s1_valid_r && s1_last_r && out_valid_r && out_stall;
  assign s1_adv   = s1_valid_r && !s1_hold;
  assign in_stall = s1_hold;
  assign in_acc   = in_valid && !in_stall;
  assign out_load = s1_adv && s1_last_r;

  // Raster position
  assign col_last = (col_r == width_m1);
  assign row_last = (row_r == height_m1);

  always_comb begin
    col_nxt = col_r;
    row_nxt = row_r;
    if (in_acc) begin
      if (col_last) begin
        col_nxt = '0;
        row_nxt = row_last ? '0 : row_r + ROW_BITS'(1);
      end else begin
        col_nxt = col_r + COL_BITS'(1);
      end
    end
  end

  // Line stores: middle rolls into upper in the cycle after the read
  always_ff @(posedge clk) begin
    if (in_acc) begin
      up_rd_r         <= up_mem[col_r];
      mid_rd_r        <= mid_mem[col_r];
      mid_mem[col_r]  <= in_pixel;
    end
    if (s1_valid_r) begin
      up_mem[s1_col_r] <= mid_rd_r;
    end
  end

  // Stage 1 payload
  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_pixel_r   <= in_pixel;
      s1_col_r     <= col_r;
      s1_row_ge2_r <= (row_r >= ROW_BITS'(2));
      s1_last_r    <= col_last && row_last;
    end
  end

  // Window shift when a column leaves stage 1
  always_ff @(posedge clk) begin
    if (s1_adv) begin
      up1_r  <= up_rd_r;
      mid1_r <= mid_rd_r;
      mid2_r <= mid1_r;
      pix1_r <= s1_pixel_r;
    end
  end

  // Cross sum for the center one column back
  assign cross_sum = SUM_BITS'(up1_r) + SUM_BITS'(mid2_r) + SUM_BITS'(mid1_r)
                   + SUM_BITS'(mid_rd_r) + SUM_BITS'(pix1_r);
  assign is_center = s1_row_ge2_r && (s1_col_r >= COL_BITS'(2));
  assign is_star   = is_center && (cross_sum >= SUM_BITS'(STAR_SUM_MIN));

  // Saturating count including the current center
  assign frame_total = (is_star && count_r != COUNT_MAX) ? count_r + COUNT_BITS'(1) : count_r;

  always_comb begin
    count_nxt = count_r;
    if (cfg_we) begin
      count_nxt = '0;
    end else if (s1_adv) begin
      count_nxt = s1_last_r ? '0 : frame_total;
    end
  end

  assign s1_valid_nxt  = in_acc ? 1'b1 : (s1_adv ? 1'b0 : s1_valid_r);
  assign out_valid_nxt = out_load ? 1'b1 : (out_valid_r && out_stall);

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r     <= DIM_BITS'(MAX_WIDTH);
      height_r    <= DIM_BITS'(MAX_HEIGHT);
      col_r       <= '0;
      row_r       <= '0;
      count_r     <= '0;
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        // a write restarts the frame
        if (cfg_index == CFG_IDX_WIDTH) begin
          width_r <= cfg_data;
        end else begin
          height_r <= cfg_data;
        end
        col_r <= '0;
        row_r <= '0;
      end else begin
        col_r <= col_nxt;
        row_r <= row_nxt;
      end
      count_r     <= count_nxt;
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (out_load) begin
      out_count_r <= frame_total;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_star_count = out_count_r;

  // Checks
  a_col_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    col_r <= width_m1) else $error("column position beyond row width");

  a_row_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    row_r <= height_m1) else $error("row position beyond frame height");

  a_count_cleared: assert property (@(posedge clk) disable iff (!rst_n)
    out_load |=> count_r == '0) else $error("count not restarted after frame");

  a_count_monotonic: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_adv && !s1_last_r && !cfg_we) |=> count_r >= $past(count_r))
    else $error("star count decreased within a frame");

  a_hold_needs_full_out: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (out_valid_r && s1_valid_r && s1_last_r))
    else $error("input stalled without a pending frame count");

endmodule

// ===== tb/sv/cross_stencil_star_counter_unit_tb.sv =====
`timescale 1ns / 1ps
// Testbench: directed and random frame streams checked against a cycle-free star count predictor.
module cross_stencil_star_counter_unit_tb;
  import cssc_pkg::*;

  localparam int HALF_PERIOD    = 4;
  localparam int RESET_CYCLES   = 12;
  localparam int SETTLE_CYCLES  = 8;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int PRESSURE_HOLD  = 300;
  localparam int RANDOM_PIXELS  = 500;
  localparam int STAR_DIVISOR   = 5;
  localparam int STAR_FLOOR     = 6;

  // pixel value mixes per frame
  typedef enum int {PIX_FULL, PIX_NEAR, PIX_SPARSE, PIX_RAILS} pixel_mix_t;

  logic                  clk       = 1'b0;
  logic                  rst_n     = 1'b0;
  logic                  cfg_we    = 1'b0;
  logic                  cfg_index = CFG_IDX_WIDTH;
  logic [DIM_BITS-1:0]   cfg_data  = '0;
  logic                  in_valid  = 1'b0;
  logic [PIXEL_BITS-1:0] in_pixel  = '0;
  logic                  out_stall = 1'b0;
  logic                  in_stall;
  logic                  out_valid;
  logic [COUNT_BITS-1:0] out_star_count;

  // predictor state
  logic [DIM_BITS-1:0]   width_setting;
  logic [DIM_BITS-1:0]   height_setting;
  int unsigned           col_pos;
  int unsigned           row_pos;
  logic [COUNT_BITS-1:0] frame_stars;
  logic [PIXEL_BITS-1:0] row_two_up [MAX_WIDTH];
  logic [PIXEL_BITS-1:0] row_one_up [MAX_WIDTH];
  logic [PIXEL_BITS-1:0] row_current [MAX_WIDTH];

  logic [COUNT_BITS-1:0] star_counts_due[$];
  logic [PIXEL_BITS-1:0] pixel_queue[$];
  int                    error_count   = 0;
  bit                    calm          = 1'b0;
  int                    hold_requests = 0;

  int                    gap_left      = 0;
  logic [COUNT_BITS-1:0] finished_count;
  int                    stall_left    = 0;
  int                    holds_served  = 0;
  logic [COUNT_BITS-1:0] wanted_count;
  int                    quiet_cycles  = 0;

  always begin
    #HALF_PERIOD clk = 1'b1;
    #HALF_PERIOD clk = 1'b0;
  end

  cross_stencil_star_counter_unit uut (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_pixel       (in_pixel),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_star_count (out_star_count)
  );

  // zero means one, oversize saturates
  function automatic int unsigned clamp_dim(logic [DIM_BITS-1:0] v, int unsigned lim);
    if (v == '0) return 1;
    if (v > lim) return lim;
    return 32'(v);
  endfunction

  // advance the stencil by one pixel; returns 1 with the total at the end of a frame
  function automatic bit count_pixel(input logic [PIXEL_BITS-1:0] px,
                                     output logic [COUNT_BITS-1:0] total);
    int unsigned w;
    int unsigned h;
    int unsigned sum;
    w = clamp_dim(width_setting, MAX_WIDTH);
    h = clamp_dim(height_setting, MAX_HEIGHT);
    total = '0;
    // center is (row-1, col): cross of up, left, center, right, down
    if (row_pos >= 2 && col_pos >= 1 && col_pos + 2 <= w) begin
      sum = row_two_up[col_pos] + row_one_up[col_pos - 1] + row_one_up[col_pos]
          + row_one_up[col_pos + 1] + px;
      if (sum / STAR_DIVISOR > STAR_FLOOR && frame_stars != '1) frame_stars++;
    end
    row_current[col_pos] = px;
    if (col_pos + 1 >= w) begin
      col_pos = 0;
      row_two_up = row_one_up;
      row_one_up = row_current;
      if (row_pos + 1 >= h) begin
        total = frame_stars;
        frame_stars = '0;
        row_pos = 0;
        return 1'b1;
      end
      row_pos++;
    end else begin
      col_pos++;
    end
    return 1'b0;
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (calm || r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  function automatic int pick_stall();
    int r;
    r = $urandom_range(0, 99);
    if (calm || r < 70) return 0;
    if (r < 93) return $urandom_range(1, 4);
    if (r < 99) return $urandom_range(5, 20);
    return $urandom_range(100, 250);
  endfunction

  function automatic logic [PIXEL_BITS-1:0] pick_pixel(pixel_mix_t mix);
    case (mix)
      PIX_NEAR:   return PIXEL_BITS'($urandom_range(0, 14));
      PIX_SPARSE: return ($urandom_range(0, 9) == 0) ? PIXEL_BITS'($urandom_range(0, 255)) : '0;
      PIX_RAILS:  return $urandom_range(0, 1) ? '1 : '0;
      default:    return PIXEL_BITS'($urandom_range(0, 255));
    endcase
  endfunction

  // driver: presents queued pixels, updates the predictor on each accepted transaction
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      width_setting = 11'd1024;
      height_setting = 11'd1024;
      col_pos = 0;
      row_pos = 0;
      frame_stars = '0;
      gap_left = 0;
    end else begin
      // config write restarts the frame, line contents stay
      if (cfg_we) begin
        if (cfg_index == CFG_IDX_WIDTH) width_setting = cfg_data;
        else height_setting = cfg_data;
        col_pos = 0;
        row_pos = 0;
        frame_stars = '0;
      end
      if (in_valid && !in_stall) begin
        if (count_pixel(in_pixel, finished_count)) star_counts_due.push_back(finished_count);
      end
      if (!in_valid || !in_stall) begin
        if (gap_left > 0) begin
          in_valid <= 1'b0;
          gap_left--;
        end else if (pixel_queue.size() > 0) begin
          in_valid <= 1'b1;
          in_pixel <= pixel_queue.pop_front();
          gap_left = pick_gap();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // monitor: checks frame counts, drives random output stalls and requested long holds
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (star_counts_due.size() == 0) begin
        $error("star_count: no frame pending, expected none, actual %0d", out_star_count);
        error_count++;
      end else begin
        wanted_count = star_counts_due.pop_front();
        if (out_star_count !== wanted_count) begin
          $error("star_count mismatch: expected %0d, actual %0d", wanted_count, out_star_count);
          error_count++;
        end
      end
    end
    if (holds_served < hold_requests) begin
      holds_served++;
      stall_left = PRESSURE_HOLD;
    end else if (stall_left == 0) begin
      stall_left = pick_stall();
    end
    if (stall_left > 0) begin
      out_stall <= 1'b1;
      stall_left--;
    end else begin
      out_stall <= 1'b0;
    end
  end

  // watchdog: cycles without any transaction or config write
  always @(posedge clk) begin
    if (!rst_n || cfg_we || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles + 1 >= WATCHDOG_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic write_dims(int unsigned w_code, int unsigned h_code);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= CFG_IDX_WIDTH;
    cfg_data  <= DIM_BITS'(w_code);
    @(posedge clk);
    cfg_index <= CFG_IDX_HEIGHT;
    cfg_data  <= DIM_BITS'(h_code);
    @(posedge clk);
    cfg_we    <= 1'b0;
  endtask

  // all pixels taken and every count seen, then let the pipeline settle
  task automatic wait_drained();
    do @(negedge clk);
    while (pixel_queue.size() != 0 || in_valid || star_counts_due.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic queue_frame(int unsigned w, int unsigned h, pixel_mix_t mix,
                             int unsigned limit);
    int unsigned n;
    n = (w * h < limit) ? w * h : limit;
    for (int unsigned i = 0; i < n; i++) pixel_queue.push_back(pick_pixel(mix));
  endtask

  initial begin
    int unsigned sent;
    int unsigned w;
    int unsigned h;
    int unsigned part;
    int          frames;
    pixel_mix_t  mix;

    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;

    // zero dimensions act as a single-pixel frame
    write_dims(0, 0);
    pixel_queue.push_back(8'd255);
    wait_drained();
    // 3x3: cross sum right at the threshold, then one below it
    write_dims(3, 3);
    pixel_queue = '{8'd255, 8'd7, 8'd255, 8'd7, 8'd7, 8'd7, 8'd255, 8'd7, 8'd255,
                    8'd0, 8'd7, 8'd0, 8'd7, 8'd6, 8'd7, 8'd0, 8'd7, 8'd0};
    wait_drained();

    // widest frame (oversize width code), tallest frame (oversize height code)
    write_dims(2047, 3);
    queue_frame(1024, 3, PIX_NEAR, 1024 * 3);
    wait_drained();
    write_dims(1, 2047);
    queue_frame(1, 1024, PIX_FULL, 1024);
    wait_drained();

    // random small frames, sometimes cut short before the next setting
    sent = 0;
    while (sent < RANDOM_PIXELS) begin
      w = ($urandom_range(0, 99) < 85) ? $urandom_range(1, 12) : $urandom_range(13, 48);
      h = ($urandom_range(0, 99) < 85) ? $urandom_range(1, 8) : $urandom_range(9, 20);
      calm = ($urandom_range(0, 3) == 0);
      write_dims((w == 1 && $urandom_range(0, 1)) ? 0 : w,
                 (h == 1 && $urandom_range(0, 1)) ? 0 : h);
      frames = $urandom_range(1, 4);
      repeat (frames) begin
        queue_frame(w, h, pixel_mix_t'($urandom_range(0, 3)), w * h);
        sent += w * h;
      end
      if (w * h > 1 && $urandom_range(0, 4) == 0) begin
        part = $urandom_range(1, w * h - 1);
        mix = pixel_mix_t'($urandom_range(0, 3));
        queue_frame(w, h, mix, part);
        sent += part;
      end
      wait_drained();
    end

    // long output hold-off with a steady pixel stream behind it
    calm = 1'b1;
    write_dims(3, 3);
    hold_requests++;
    repeat (6) queue_frame(3, 3, PIX_FULL, 9);
    wait_drained();
    calm = 1'b0;

    repeat (20) @(posedge clk);
    if (error_count == 0 && star_counts_due.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

// ===== files.f =====
src/cssc_pkg.sv
src/cross_stencil_star_counter_unit.sv
tb/sv/cross_stencil_star_counter_unit_tb.sv
